>>> design/abu_pkg.sv
// shared constants, codes and the factor helper for the argb blend unit
package abu_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned NumCh   = 4;
  localparam int unsigned PixW    = ChW * NumCh;
  localparam int unsigned FacW    = ChW + 1;
  localparam int unsigned ProdW   = 16;
  localparam int unsigned SumW    = 18;
  localparam int unsigned SelW    = 3;
  localparam int unsigned OpW     = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 3;
  localparam int unsigned AlphaCh = 3;

  localparam logic [ChW-1:0]  ChMax   = 8'hff;
  localparam logic [SumW-1:0] RoundBias = 18'd127;

  // factor select codes
  localparam logic [SelW-1:0] FAC_ZERO     = 3'd0;
  localparam logic [SelW-1:0] FAC_ONE      = 3'd1;
  localparam logic [SelW-1:0] FAC_SRC_A    = 3'd2;
  localparam logic [SelW-1:0] FAC_INV_SRCA = 3'd3;
  localparam logic [SelW-1:0] FAC_SRC_C    = 3'd4;
  localparam logic [SelW-1:0] FAC_INV_SRCC = 3'd5;
  localparam logic [SelW-1:0] FAC_DST_C    = 3'd6;
  localparam logic [SelW-1:0] FAC_INV_DSTC = 3'd7;

  // blend op codes, anything else is reverse subtract
  localparam logic [OpW-1:0] OP_ADD  = 2'd0;
  localparam logic [OpW-1:0] OP_SUB  = 2'd1;
  localparam logic [OpW-1:0] OP_RSUB = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_SRC_FACTOR = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DST_FACTOR = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BLEND_OP   = 2'd2;

  // pick an 8-bit factor and stretch it to 0..256
  function automatic logic [FacW-1:0] factor_scale(input logic [SelW-1:0] sel,
                                                   input logic [ChW-1:0]  src_a,
                                                   input logic [ChW-1:0]  src_c,
                                                   input logic [ChW-1:0]  dst_c);
    logic [ChW-1:0] f;
    case (sel)
      FAC_ZERO:     f = '0;
      FAC_ONE:      f = ChMax;
      FAC_SRC_A:    f = src_a;
      FAC_INV_SRCA: f = ChMax - src_a;
      FAC_SRC_C:    f = src_c;
      FAC_INV_SRCC: f = ChMax - src_c;
      FAC_DST_C:    f = dst_c;
      default:      f = ChMax - dst_c;
    endcase
    return {1'b0, f} + {{(FacW-1){1'b0}}, f[ChW-1]};
  endfunction

endpackage

>>> design/argb_blend_unit.sv
// argb blend unit: per-channel factor select, multiply, combine, round and clamp
// throughput: one pixel per cycle when nothing stalls; stage 1 selects factors,
// stage 2 multiplies, stage 3 adds or subtracts, rounds and clamps into the
// output register; each stage holds its item while the next is full,
// so a stall loses nothing
// reset clears all stage valid bits and sets src factor one, dst factor zero, op add
module argb_blend_unit import abu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [2*PixW-1:0]    s_axis_tdata,  // frag_color [31:0], dest_color [63:32]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [PixW-1:0]      m_axis_tdata   // blended_color [31:0]
);

  logic [SelW-1:0] src_sel_q, dst_sel_q;
  logic [OpW-1:0]  op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_sel_q <= FAC_ONE;
      dst_sel_q <= FAC_ZERO;
      op_q      <= OP_ADD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SRC_FACTOR: src_sel_q <= cfg_data_i;
        REG_DST_FACTOR: dst_sel_q <= cfg_data_i;
        REG_BLEND_OP:   op_q      <= cfg_data_i[OpW-1:0];
        default: ;
      endcase
    end
  end

  logic [PixW-1:0] frag, dest;
  assign frag = s_axis_tdata[PixW-1:0];
  assign dest = s_axis_tdata[2*PixW-1:PixW];

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 1: factors and channels
  logic [FacW-1:0] sf_d [NumCh], df_d [NumCh];
  logic [FacW-1:0] sf_q [NumCh], df_q [NumCh];
  logic [ChW-1:0]  sc_q [NumCh], dc_q [NumCh];

  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      sf_d[k] = factor_scale(src_sel_q, frag[AlphaCh*ChW +: ChW], frag[k*ChW +: ChW],
                             dest[k*ChW +: ChW]);
      df_d[k] = factor_scale(dst_sel_q, frag[AlphaCh*ChW +: ChW], frag[k*ChW +: ChW],
                             dest[k*ChW +: ChW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      for (int k = 0; k < NumCh; k++) begin
        sf_q[k] <= sf_d[k];
        df_q[k] <= df_d[k];
        sc_q[k] <= frag[k*ChW +: ChW];
        dc_q[k] <= dest[k*ChW +: ChW];
      end
    end
  end

  // stage 2: products, at most 256 * 255 so 16 bits hold them
  logic [ProdW-1:0] sp_q [NumCh], dp_q [NumCh];
  logic [FacW+ChW-1:0] sp_d [NumCh], dp_d [NumCh];

  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      sp_d[k] = sf_q[k] * sc_q[k];
      dp_d[k] = df_q[k] * dc_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      for (int k = 0; k < NumCh; k++) begin
        sp_q[k] <= sp_d[k][ProdW-1:0];
        dp_q[k] <= dp_d[k][ProdW-1:0];
      end
    end
  end

  // stage 3: combine, round to nearest with ties down, clamp
  logic [SumW-1:0] sum_d [NumCh];
  logic [PixW-1:0] res_d, res_q;

  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      case (op_q)
        OP_ADD:  sum_d[k] = {2'b00, sp_q[k]} + {2'b00, dp_q[k]};
        OP_SUB:  sum_d[k] = {2'b00, sp_q[k]} - {2'b00, dp_q[k]};
        default: sum_d[k] = {2'b00, dp_q[k]} - {2'b00, sp_q[k]};
      endcase
      sum_d[k] = sum_d[k] + RoundBias;
      if (sum_d[k][SumW-1])      res_d[k*ChW +: ChW] = '0;
      else if (sum_d[k][SumW-2]) res_d[k*ChW +: ChW] = ChMax;
      else                       res_d[k*ChW +: ChW] = sum_d[k][ProdW-1:ChW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) res_q <= res_d;
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = res_q;

endmodule

>>> design/abu_checker.sv
// port-level checks for the argb blend unit and their bind
module abu_checker import abu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [CfgIdxW-1:0] cfg_idx_i,
  input logic [CfgW-1:0]    cfg_data_i,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [2*PixW-1:0]  s_axis_tdata,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [PixW-1:0]    m_axis_tdata
);

  // nothing comes out right after reset lets go
  a_no_out_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled result keeps its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // an empty output register means the pipe can take a pixel
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready with output empty");

  // with the output side taking, a transferred pixel passes stages 1, 2 and 3 and comes out valid
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      |=> m_axis_tvalid)
    else $error("result missing three cycles after transfer");

endmodule

bind argb_blend_unit abu_checker u_abu_checker (.*);

>>> dv/argb_blend_unit_chk.sv
// checker for the argb blend unit: watches config writes and both streams, predicts and compares
module argb_blend_unit_chk import abu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [2*PixW-1:0] s_axis_tdata,   // frag_color [31:0], dest_color [63:32]
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [PixW-1:0]   m_axis_tdata,   // blended_color [31:0]
  output int                fail_cnt_o,
  output int                pending_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxReports = 10;
  localparam int Bias       = 127;

  typedef struct packed {
    logic [PixW-1:0] frag;
    logic [PixW-1:0] dest;
    logic [PixW-1:0] blended;
  } blend_rec_t;

  blend_rec_t      blend_q [$];
  logic [SelW-1:0] src_sel;
  logic [SelW-1:0] dst_sel;
  logic [OpW-1:0]  op_sel;

  // 8-bit factor for one channel, before stretching
  function automatic logic [ChW-1:0] raw_factor(input logic [SelW-1:0] sel,
                                                input logic [ChW-1:0]  frag_a,
                                                input logic [ChW-1:0]  frag_c,
                                                input logic [ChW-1:0]  dest_c);
    case (sel)
      FAC_ZERO:     return '0;
      FAC_ONE:      return ChMax;
      FAC_SRC_A:    return frag_a;
      FAC_INV_SRCA: return ChMax - frag_a;
      FAC_SRC_C:    return frag_c;
      FAC_INV_SRCC: return ChMax - frag_c;
      FAC_DST_C:    return dest_c;
      default:      return ChMax - dest_c;
    endcase
  endfunction

  function automatic logic [PixW-1:0] blend_argb(input logic [PixW-1:0] frag,
                                                 input logic [PixW-1:0] dest,
                                                 input logic [SelW-1:0] sf,
                                                 input logic [SelW-1:0] df,
                                                 input logic [OpW-1:0]  op);
    logic [PixW-1:0] pix;
    logic [ChW-1:0]  frag_a;
    logic [ChW-1:0]  frag_c;
    logic [ChW-1:0]  dest_c;
    logic [ChW-1:0]  fs;
    logic [ChW-1:0]  fd;
    int              s_term;
    int              d_term;
    int              acc;
    pix    = '0;
    frag_a = frag[ChW*AlphaCh +: ChW];
    for (int k = 0; k < NumCh; k++) begin
      frag_c = frag[ChW*k +: ChW];
      dest_c = dest[ChW*k +: ChW];
      fs = raw_factor(sf, frag_a, frag_c, dest_c);
      fd = raw_factor(df, frag_a, frag_c, dest_c);
      // stretch 0..255 to 0..256 by adding the msb
      s_term = (int'(fs) + int'(fs[ChW-1])) * int'(frag_c);
      d_term = (int'(fd) + int'(fd[ChW-1])) * int'(dest_c);
      case (op)
        OP_ADD:  acc = s_term + d_term;
        OP_SUB:  acc = s_term - d_term;
        default: acc = d_term - s_term;
      endcase
      acc = acc + Bias;
      if (acc < 0)
        pix[ChW*k +: ChW] = '0;
      else if ((acc >>> 8) > int'(ChMax))
        pix[ChW*k +: ChW] = ChMax;
      else
        pix[ChW*k +: ChW] = acc[15:8];
    end
    return pix;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    blend_rec_t rec;
    if (!rst_ni) begin
      src_sel = FAC_ONE;
      dst_sel = FAC_ZERO;
      op_sel  = OP_ADD;
      blend_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
      checked_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SRC_FACTOR: src_sel = cfg_data_i[SelW-1:0];
          REG_DST_FACTOR: dst_sel = cfg_data_i[SelW-1:0];
          REG_BLEND_OP:   op_sel  = cfg_data_i[OpW-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (blend_q.size() == 0) begin
          if (fail_cnt_o < MaxReports)
            $display("unexpected result %h with no pixel outstanding", m_axis_tdata);
          fail_cnt_o++;
        end else begin
          rec = blend_q.pop_front();
          checked_o++;
          if (m_axis_tdata !== rec.blended) begin
            if (fail_cnt_o < MaxReports)
              $display("blend mismatch: frag %h dest %h expected %h got %h",
                       rec.frag, rec.dest, rec.blended, m_axis_tdata);
            fail_cnt_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rec.frag    = s_axis_tdata[PixW-1:0];
        rec.dest    = s_axis_tdata[2*PixW-1:PixW];
        rec.blended = blend_argb(rec.frag, rec.dest, src_sel, dst_sel, op_sel);
        blend_q.push_back(rec);
      end
      pending_o = blend_q.size();
    end
  end

endmodule

>>> dv/argb_blend_unit_tb.sv
// testbench top for the argb blend unit: clock, reset, stimulus, result sink and verdict
module argb_blend_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import abu_pkg::*;

  localparam int unsigned TotalPixels = 1450;
  localparam int unsigned RxLongHold  = 80;
  localparam int unsigned PressureLen = 60;
  localparam int unsigned PressurePhase = 3;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned CycleLimit  = 400000;

  // codes outside the named ranges
  localparam logic [CfgIdxW-1:0] REG_UNUSED  = 2'd3;
  localparam logic [OpW-1:0]     OP_RSUB_ALT = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [2*PixW-1:0]   s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [PixW-1:0]     m_axis_tdata;

  int          fails;
  int          pending;
  int          checked;
  int unsigned cycle_cnt = 0;
  int unsigned pixels_sent = 0;
  int unsigned settings_used = 0;
  logic        tx_calm = 1'b0;
  logic        rx_calm = 1'b0;
  logic        rx_long_hold = 1'b0;

  logic [PixW-1:0] dir_frag [5] = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff,
                                    32'h0000_0000, 32'h807f_01fe};
  logic [PixW-1:0] dir_dest [5] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000,
                                    32'hffff_ffff, 32'h7f80_fe01};

  argb_blend_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  argb_blend_unit_chk u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_cnt_o    (fails),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timed out after %0d cycles, %0d pixels outstanding", cycle_cnt, pending);
      $display("FAIL");
      $finish;
    end
  end

  // random pixel with channel extremes and midpoints mixed in
  function automatic logic [PixW-1:0] rand_pixel();
    logic [PixW-1:0] pix;
    for (int k = 0; k < NumCh; k++) begin
      case ($urandom_range(0, 7))
        0:       pix[ChW*k +: ChW] = 8'h00;
        1:       pix[ChW*k +: ChW] = 8'hff;
        2:       pix[ChW*k +: ChW] = 8'h7f;
        3:       pix[ChW*k +: ChW] = 8'h80;
        default: pix[ChW*k +: ChW] = ChW'($urandom_range(0, 255));
      endcase
    end
    return pix;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_pixel(input logic [PixW-1:0] frag, input logic [PixW-1:0] dest);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dest, frag};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  // only called with the pipeline empty
  task automatic configure(input logic [SelW-1:0] sf, input logic [SelW-1:0] df,
                           input logic [CfgW-1:0] op_word);
    write_reg(REG_SRC_FACTOR, sf);
    write_reg(REG_DST_FACTOR, df);
    write_reg(REG_BLEND_OP, op_word);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic run_directed(input logic [SelW-1:0] sf, input logic [SelW-1:0] df,
                              input logic [CfgW-1:0] op_word);
    configure(sf, df, op_word);
    for (int k = 0; k < 5; k++) send_pixel(dir_frag[k], dir_dest[k]);
    drain();
  endtask

  // result sink: per-result stall, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (rx_long_hold) begin
        stall = RxLongHold;
        rx_long_hold = 1'b0;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 11);
      end
      m_axis_tready <= (stall == 0);
      if (stall > 0) begin
        repeat (stall) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned     phase;
    int unsigned     plen;
    logic [SelW-1:0] sf;
    logic [SelW-1:0] df;
    logic [OpW-1:0]  op;
    logic            op_hi;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // out-of-range index must leave the reset settings alone
    write_reg(REG_UNUSED, 3'b111);
    cfg_we_i <= 1'b0;
    for (int k = 1; k < 5; k++) send_pixel(dir_frag[k], dir_dest[k]);
    drain();

    run_directed(FAC_ONE, FAC_ONE, {1'b0, OP_ADD});
    run_directed(FAC_SRC_A, FAC_INV_SRCA, {1'b0, OP_SUB});
    run_directed(FAC_SRC_C, FAC_DST_C, {1'b0, OP_RSUB});
    run_directed(FAC_INV_SRCC, FAC_INV_DSTC, {1'b1, OP_RSUB_ALT});

    phase = 0;
    while (pixels_sent < TotalPixels) begin
      case (phase)
        0: begin
          sf = FAC_ZERO;
          df = FAC_ZERO;
          op = OP_ADD;
        end
        1: begin
          sf = FAC_INV_DSTC;
          df = FAC_INV_DSTC;
          op = OP_RSUB_ALT;
        end
        default: begin
          sf = SelW'(phase % 8);
          df = SelW'($urandom_range(0, 7));
          op = OpW'($urandom_range(0, 3));
        end
      endcase
      op_hi   = 1'($urandom_range(0, 1));
      tx_calm = (phase % 6 == 2) || (phase == PressurePhase);
      rx_calm = (phase % 6 == 2);
      configure(sf, df, {op_hi, op});
      plen = (phase == PressurePhase) ? PressureLen : $urandom_range(15, 45);
      if (plen > TotalPixels - pixels_sent) plen = TotalPixels - pixels_sent;
      // back up the pipeline until the input stalls
      if (phase == PressurePhase) rx_long_hold = 1'b1;
      repeat (plen) send_pixel(rand_pixel(), rand_pixel());
      drain();
      phase++;
    end

    repeat (SettleCycles) @(negedge clk_i);
    $display("sent %0d pixels under %0d blend settings, all four op codes and an ignored write",
             pixels_sent, settings_used);
    $display("%0d results compared, %0d failures", checked, fails);
    if (fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
